// ===== rtl/assert_macros.svh =====
// assertion macros for the rtl modules, included by wptf_ctrl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// implication checked in the cycle after the condition
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

// ===== rtl/wptf_pkg.sv =====
// shared types and constants for the waypoint follower
// no dependencies
package wptf_pkg;
    localparam int unsigned MaxWaypointsDef = 16;
    localparam int unsigned CordicStepsDef  = 16;
    localparam logic [4:0]  WpCountRst  = 5'd14;
    localparam logic [15:0] FwdSpeedRst = 16'd154;
    localparam logic [15:0] TurnRateRst = 16'd15646;
    localparam logic [14:0] TurnThrRst  = 15'd1043;
    localparam logic [30:0] ArrRadRst   = 31'd19661;
    localparam logic [2:0] CfgCount = 3'd0;
    localparam logic [2:0] CfgSpeed = 3'd1;
    localparam logic [2:0] CfgRate  = 3'd2;
    localparam logic [2:0] CfgThr   = 3'd3;
    localparam logic [2:0] CfgRad   = 3'd4;
    localparam logic signed [35:0] CordicGainInit = 36'sd652032874;
    localparam logic [16:0] MagScale = 17'd39797;

    // datapath commands
    typedef struct packed {
        logic load_in;
        logic vec_init;
        logic vec_step;
        logic decide;
        logic rot_init;
        logic rot_step;
        logic mul_step;
        logic finish;
    } t_cmd;

    // datapath status
    typedef struct packed {
        logic is_tick;
        logic turning;
        logic last_iter;
    } t_sts;

    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] r;
        begin
            case (i)
                5'd0:  r = 32'h20000000; 5'd1:  r = 32'h12E4051D;
                5'd2:  r = 32'h09FB385B; 5'd3:  r = 32'h051111D4;
                5'd4:  r = 32'h028B0D43; 5'd5:  r = 32'h0145D7E1;
                5'd6:  r = 32'h00A2F61E; 5'd7:  r = 32'h00517C55;
                5'd8:  r = 32'h0028BE53; 5'd9:  r = 32'h00145F2E;
                5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
                5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
                5'd14: r = 32'h0000A2F9; 5'd15: r = 32'h0000517C;
                5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
                5'd18: r = 32'h00000A2F; 5'd19: r = 32'h00000517;
                5'd20: r = 32'h0000028B; 5'd21: r = 32'h00000145;
                5'd22: r = 32'h000000A2; 5'd23: r = 32'h00000051;
                5'd24: r = 32'h00000028; 5'd25: r = 32'h00000014;
                5'd26: r = 32'h0000000A; 5'd27: r = 32'h00000005;
                5'd28: r = 32'h00000002; 5'd29: r = 32'h00000001;
                default: r = 32'h00000000;
            endcase
            return r;
        end
    endfunction
endpackage

// ===== rtl/waypoint_turn_then_go_follower.sv =====
// top level of the turn-then-go waypoint follower
// depends on wptf_pkg, wptf_ctrl, wptf_dp
//
// Input stream: one transfer is a load (tuser 0) that writes a waypoint,
// or a tick (tuser 1) that carries pose and step time. Loads give no result;
// each tick gives one result transfer on the master side.
// A tick runs the vectoring iterations and a decision, then, when driving,
// the rotation iterations, then the finish steps before its result is valid;
// after the result transfer the block returns to idle before the next input
// is taken. A load writes the table and passes through dispatch to idle.
// A single shared cordic iterator does both passes; one item is in work at a time.
// A result stays on the master side until taken; no new item is taken meanwhile.
// Configuration writes land at once through i_cfg_we / i_cfg_idx / i_cfg_data.
// Reset restores register defaults and target index 0; the waypoint table
// holds nothing defined until written.
module waypoint_turn_then_go_follower import wptf_pkg::*; #(
    parameter int unsigned MAX_WAYPOINTS = MaxWaypointsDef,
    parameter int unsigned CORDIC_STEPS  = CordicStepsDef
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pos_x, pos_y, heading, step_time, entry_index, entry_x, entry_y
    input  logic [167:0] s_axis_tdata,
    // kind
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // next_x, next_y, next_heading, turning, reached, target_slot
    output logic [87:0]  m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [30:0]  i_cfg_data
);
    logic [4:0]  r_wp_count;
    logic [15:0] r_fwd_speed, r_turn_rate;
    logic [14:0] r_turn_thr;
    logic [30:0] r_arr_rad;
    t_cmd w_cmd;
    t_sts w_sts;
    logic [163:0] w_data;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp_count  <= WpCountRst;
            r_fwd_speed <= FwdSpeedRst;
            r_turn_rate <= TurnRateRst;
            r_turn_thr  <= TurnThrRst;
            r_arr_rad   <= ArrRadRst;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CfgCount: r_wp_count  <= i_cfg_data[4:0];
                CfgSpeed: r_fwd_speed <= i_cfg_data[15:0];
                CfgRate:  r_turn_rate <= i_cfg_data[15:0];
                CfgThr:   r_turn_thr  <= i_cfg_data[14:0];
                CfgRad:   r_arr_rad   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // field bits without the byte padding
    assign w_data = s_axis_tdata[163:0];

    wptf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_out_ready(m_axis_tready),
        .i_sts      (w_sts),
        .o_in_ready (s_axis_tready),
        .o_out_valid(m_axis_tvalid),
        .o_cmd      (w_cmd)
    );

    wptf_dp #(
        .MAX_WAYPOINTS(MAX_WAYPOINTS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_data     (w_data),
        .i_kind     (s_axis_tuser),
        .i_wp_count (r_wp_count),
        .i_fwd_speed(r_fwd_speed),
        .i_turn_rate(r_turn_rate),
        .i_turn_thr (r_turn_thr),
        .i_arr_rad  (r_arr_rad),
        .o_sts      (w_sts),
        .o_result   (m_axis_tdata)
    );
endmodule

// ===== rtl/wptf_ctrl.sv =====
// controller state machine sequencing load, cordic and output
// depends on wptf_pkg, assert_macros.svh
`include "assert_macros.svh"
module wptf_ctrl import wptf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output logic o_in_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);
    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_DISP = 8'b0000_0010,
        S_VEC  = 8'b0000_0100,
        S_DEC  = 8'b0000_1000,
        S_ROT  = 8'b0001_0000,
        S_MUL  = 8'b0010_0000,
        S_FIN  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load_in = i_in_valid;
                if (i_in_valid) n_state = S_DISP;
            end
            S_DISP: begin
                if (i_sts.is_tick) begin
                    o_cmd.vec_init = 1'b1;
                    n_state = S_VEC;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_VEC: begin
                o_cmd.vec_step = 1'b1;
                if (i_sts.last_iter) n_state = S_DEC;
            end
            S_DEC: begin
                o_cmd.decide = 1'b1;
                n_state = S_ROT;
            end
            S_ROT: begin
                if (i_sts.turning) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.rot_init = 1'b1;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.rot_step = 1'b1;
                if (i_sts.last_iter) n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.mul_step = 1'b1;
                if (i_sts.last_iter) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    `ASSERT_IMPL(a_one_side, i_clk, i_rst_n, o_out_valid, !o_in_ready)
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)
    `ASSERT_NEXT(a_fin_out, i_clk, i_rst_n, o_cmd.finish, o_out_valid)
endmodule

// ===== rtl/wptf_dp.sv =====
// datapath: waypoint table, shared cordic, multiplier and result registers
// depends on wptf_pkg
module wptf_dp import wptf_pkg::*; #(
    parameter int unsigned MAX_WAYPOINTS = MaxWaypointsDef,
    parameter int unsigned CORDIC_STEPS  = CordicStepsDef
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cmd         i_cmd,
    input  logic [163:0] i_data,
    input  logic         i_kind,
    input  logic [4:0]   i_wp_count,
    input  logic [15:0]  i_fwd_speed,
    input  logic [15:0]  i_turn_rate,
    input  logic [14:0]  i_turn_thr,
    input  logic [30:0]  i_arr_rad,
    output t_sts         o_sts,
    output logic [87:0]  o_result
);
    // slot and index fields are four bits wide, so at most 16 entries are reachable
    localparam int unsigned TD = (MAX_WAYPOINTS < 16) ? MAX_WAYPOINTS : 16;
    localparam int unsigned IW = $clog2(TD);
    localparam int unsigned NS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    localparam logic [4:0]  CntCap = 5'(TD);

    logic signed [31:0] r_wx [TD];
    logic signed [31:0] r_wy [TD];
    logic signed [31:0] r_tx, r_ty;
    logic signed [31:0] r_px, r_py;
    logic [15:0] r_head, r_dt;
    logic        r_kind;
    logic [3:0]  r_tidx;
    logic signed [35:0] r_x, r_y;
    logic signed [33:0] r_z;
    logic [4:0]  r_it;
    logic        r_turn, r_reach, r_flip, r_zero;
    logic [15:0] r_nh;
    logic [1:0]  r_mph;
    logic signed [31:0] r_nx, r_ny;
    logic [23:0] r_len;

    logic [3:0]  w_slot;
    assign w_slot = i_data[99:96];

    // table write, slots beyond the table are dropped
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in && !i_kind && ({28'd0, w_slot} < MAX_WAYPOINTS)) begin
            r_wx[w_slot[IW-1:0]] <= i_data[131:100];
            r_wy[w_slot[IW-1:0]] <= i_data[163:132];
        end
    end

    // input capture and registered read of the current target
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_kind <= i_kind;
            r_px   <= i_data[31:0];
            r_py   <= i_data[63:32];
            r_head <= i_data[79:64];
            r_dt   <= i_data[95:80];
            r_tx   <= r_wx[r_tidx[IW-1:0]];
            r_ty   <= r_wy[r_tidx[IW-1:0]];
        end
    end

    // cordic step signals
    logic signed [35:0] w_xs, w_ys;
    logic signed [33:0] w_at;
    logic signed [32:0] w_dx, w_dy;
    logic [31:0] w_zu;
    logic signed [33:0] w_z0, w_z1;
    assign w_xs = r_x >>> r_it;
    assign w_ys = r_y >>> r_it;
    assign w_at = {2'b00, atan_entry(r_it)};
    assign w_dx = {r_tx[31], r_tx} - {r_px[31], r_px};
    assign w_dy = {r_ty[31], r_ty} - {r_py[31], r_py};
    assign w_zu = {r_head, 16'd0};
    assign w_z0 = {{2{w_zu[31]}}, w_zu};
    assign w_z1 = {{2{~w_zu[31]}}, ~w_zu[31], w_zu[30:0]};

    // bearing, heading error, turn step and distance
    logic [31:0] w_bear;
    logic [15:0] w_err;
    logic [15:0] w_abs;
    logic [15:0] w_turnd;
    logic [31:0] w_tprod;
    logic [51:0] w_mag;
    logic [35:0] w_dist;
    logic        w_reach;
    logic        w_zero;
    assign w_bear  = r_zero ? 32'd0 : r_z[31:0];
    assign w_err   = (w_bear[31:16] + {15'd0, w_bear[15]}) - r_head;
    assign w_abs   = w_err[15] ? (16'd0 - w_err) : w_err;
    assign w_tprod = i_turn_rate * r_dt;
    assign w_turnd = w_tprod[31:16] + {15'd0, w_tprod[15]};
    assign w_mag   = $unsigned(r_x) * MagScale;
    assign w_dist  = w_mag[51:16] + {35'd0, w_mag[15]};
    assign w_reach = w_dist < {5'd0, i_arr_rad};
    assign w_zero  = (w_dx == 0) && (w_dy == 0);

    // effective waypoint count and next index
    logic [4:0] w_cnt16, w_cnt;
    assign w_cnt16 = (i_wp_count == 5'd0) ? 5'd1 :
                     (i_wp_count > 5'd16) ? 5'd16 : i_wp_count;
    assign w_cnt   = (w_cnt16 > CntCap) ? CntCap : w_cnt16;
    logic [4:0] w_nxt;
    assign w_nxt = {1'b0, r_tidx} + 5'd1;

    // forward step length
    logic [31:0] w_fprod, w_lenp;
    assign w_fprod = i_fwd_speed * r_dt;
    assign w_lenp  = w_fprod + 32'd128;

    // displacement and saturated position
    logic signed [35:0] w_trig;
    logic signed [56:0] w_prod;
    logic signed [56:0] w_sum;
    logic signed [33:0] w_disp;
    logic signed [33:0] w_pos;
    assign w_trig = r_mph[0] ? (r_flip ? -r_y : r_y) : (r_flip ? -r_x : r_x);
    assign w_prod = $signed({1'b0, r_len}) * $signed(w_trig[31:0]);
    assign w_sum  = w_prod + 57'sh20000000;
    assign w_disp = {{7{w_sum[56]}}, w_sum[56:30]};
    assign w_pos  = (r_mph[0] ? {{2{r_py[31]}}, r_py} : {{2{r_px[31]}}, r_px}) + w_disp;

    logic signed [31:0] w_sat;
    assign w_sat = (w_pos > 34'sh7FFFFFFF) ? 32'sh7FFFFFFF :
                   (w_pos < -34'sh80000000) ? 32'sh80000000 : w_pos[31:0];

    // cordic, decision and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tidx <= '0;
            r_it   <= '0;
            r_mph  <= '0;
        end else begin
            if (i_cmd.vec_init) begin
                r_it   <= '0;
                r_nx   <= r_px;
                r_ny   <= r_py;
                r_zero <= w_zero;
                if (w_dx < 0) begin
                    r_x <= -{{3{w_dx[32]}}, w_dx};
                    r_y <= -{{3{w_dy[32]}}, w_dy};
                    r_z <= 34'sh080000000;
                end else begin
                    r_x <= {{3{w_dx[32]}}, w_dx};
                    r_y <= {{3{w_dy[32]}}, w_dy};
                    r_z <= '0;
                end
            end
            if (i_cmd.vec_step) begin
                r_it <= r_it + 5'd1;
                if (r_y > 0) begin
                    r_x <= r_x + w_ys; r_y <= r_y - w_xs; r_z <= r_z + w_at;
                end else begin
                    r_x <= r_x - w_ys; r_y <= r_y + w_xs; r_z <= r_z - w_at;
                end
            end
            if (i_cmd.decide) begin
                r_reach <= w_reach;
                r_turn  <= (w_abs > {1'b0, i_turn_thr});
                r_nh    <= (w_err != 0 && !w_err[15]) ? r_head + w_turnd
                                                      : r_head - w_turnd;
                r_len   <= w_lenp[31:8];
                r_mph   <= '0;
                if (w_reach)
                    r_tidx <= (w_nxt >= w_cnt) ? 4'd0 : w_nxt[3:0];
            end
            if (i_cmd.rot_init) begin
                r_it <= '0;
                r_x  <= CordicGainInit;
                r_y  <= '0;
                r_nh <= r_head;
                if (($signed(w_z0) > 34'sh40000000) || ($signed(w_z0) < -34'sh40000000)) begin
                    r_z <= w_z1; r_flip <= 1'b1;
                end else begin
                    r_z <= w_z0; r_flip <= 1'b0;
                end
            end
            if (i_cmd.rot_step) begin
                r_it <= r_it + 5'd1;
                if (r_z >= 0) begin
                    r_x <= r_x - w_ys; r_y <= r_y + w_xs; r_z <= r_z - w_at;
                end else begin
                    r_x <= r_x + w_ys; r_y <= r_y - w_xs; r_z <= r_z + w_at;
                end
            end
            if (i_cmd.mul_step) begin
                if (r_turn) begin
                    r_mph <= 2'd1;
                end else begin
                    r_mph <= r_mph + 2'd1;
                    if (r_mph[0]) r_ny <= w_sat; else r_nx <= w_sat;
                end
            end
        end
    end

    assign o_sts.is_tick   = r_kind;
    assign o_sts.turning   = r_turn;
    assign o_sts.last_iter = (i_cmd.vec_step || i_cmd.rot_step) ? (r_it == 5'(NS - 1))
                                                                : r_mph[0];
    assign o_result = {2'd0, r_tidx, r_reach, r_turn, r_nh, r_ny, r_nx};
endmodule

// ===== dv/waypoint_turn_then_go_follower_tb.sv =====
// self-checking testbench for the turn-then-go waypoint follower
// depends on wptf_pkg and waypoint_turn_then_go_follower; a scoreboard class
// predicts every tick result and checks the master-side transfers in order
`timescale 1ns / 1ps

module waypoint_turn_then_go_follower_tb;
    import wptf_pkg::*;

    localparam logic KindLoad = 1'b0;
    localparam logic KindTick = 1'b1;
    localparam logic [2:0] CfgUnused = 3'd7;
    localparam int WatchLimit = 20000;
    localparam int DrainCycles = 60;
    localparam int NumPhases = 8;
    localparam int PhaseItems = 240;

    // first member sits in the top bits, so the pose lands in the low bits
    typedef struct packed {
        logic [3:0]         slot;
        logic               reached;
        logic               turning;
        logic [15:0]        nh;
        logic signed [31:0] ny;
        logic signed [31:0] nx;
    } t_pose_update;

    // predicts the follower and holds the pose updates still to come
    class follower_scoreboard;
        bit [4:0]  wp_count;
        bit [15:0] speed;
        bit [15:0] rate;
        bit [14:0] thr;
        bit [30:0] radius;
        longint    tab_x[16];
        longint    tab_y[16];
        bit [3:0]  tgt;
        t_pose_update pending_updates[$];
        int errors;
        int ticks;
        int arrivals;
        int turns;
        bit [31:0] arctan[16] = '{
            32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
            32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
            32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
            32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C};

        function void reset_state();
            wp_count = 5'd14;
            speed = 16'd154;
            rate = 16'd15646;
            thr = 15'd1043;
            radius = 31'd19661;
            tgt = '0;
            foreach (tab_x[i]) begin
                tab_x[i] = 0;
                tab_y[i] = 0;
            end
        endfunction

        function void write_reg(bit [2:0] idx, bit [30:0] v);
            case (idx)
                CfgCount: wp_count = v[4:0];
                CfgSpeed: speed = v[15:0];
                CfgRate:  rate = v[15:0];
                CfgThr:   thr = v[14:0];
                CfgRad:   radius = v;
                default: ;
            endcase
        endfunction

        // bearing with 2^32 units per turn and scaled distance
        function void bearing_of(longint dx, longint dy, output bit [31:0] ang,
                                 output longint mag);
            longint x, y, xs, ys;
            bit [31:0] z;
            x = dx;
            y = dy;
            z = '0;
            if (dx == 0 && dy == 0) begin
                ang = '0;
                mag = 0;
                return;
            end
            if (dx < 0) begin
                x = -dx;
                y = -dy;
                z = 32'h80000000;
            end
            for (int i = 0; i < 16; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0) begin
                    x += ys;
                    y -= xs;
                    z += arctan[i];
                end else begin
                    x -= ys;
                    y += xs;
                    z -= arctan[i];
                end
            end
            ang = z;
            mag = (x * 39797 + 32768) >>> 16;
        endfunction

        // cos and sin in Q1.30
        function void trig_of(bit [15:0] hd, output longint c, output longint s);
            bit [31:0] zu;
            longint z, x, y, xs, ys;
            bit flip;
            zu = {hd, 16'h0};
            z = longint'(signed'(zu));
            x = 652032874;
            y = 0;
            flip = 0;
            if (z > 64'sh40000000 || z < -64'sh40000000) begin
                z = longint'(signed'(zu + 32'h80000000));
                flip = 1;
            end
            for (int i = 0; i < 16; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0) begin
                    x -= ys;
                    y += xs;
                    z -= longint'(arctan[i]);
                end else begin
                    x += ys;
                    y -= xs;
                    z += longint'(arctan[i]);
                end
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        // heading that points at the current target from a pose
        function bit [15:0] aim_from(longint px, longint py);
            bit [31:0] ang, sum;
            longint mag;
            bearing_of(tab_x[tgt] - px, tab_y[tgt] - py, ang, mag);
            sum = ang + 32'h8000;
            return sum[31:16];
        endfunction

        function longint clip32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function void note_item(bit kind, bit [167:0] d);
            longint px, py, mag, c, s, len, nx, ny;
            bit [31:0] ang, sum;
            bit [15:0] hd, dt, err, nh, dturn;
            longint turn_prod;
            int errs, cnt;
            bit turn, reach;
            t_pose_update u;
            if (kind == KindLoad) begin
                tab_x[d[99:96]] = longint'(signed'(d[131:100]));
                tab_y[d[99:96]] = longint'(signed'(d[163:132]));
                return;
            end
            px = longint'(signed'(d[31:0]));
            py = longint'(signed'(d[63:32]));
            hd = d[79:64];
            dt = d[95:80];
            bearing_of(tab_x[tgt] - px, tab_y[tgt] - py, ang, mag);
            sum = ang + 32'h8000;
            err = sum[31:16] - hd;
            errs = (err >= 16'd32768) ? int'(err) - 65536 : int'(err);
            nx = px;
            ny = py;
            nh = hd;
            turn = ((errs < 0) ? -errs : errs) > int'(thr);
            if (turn) begin
                turn_prod = (longint'(rate) * longint'(dt) + 32768) >> 16;
                dturn = turn_prod[15:0];
                nh = (errs > 0) ? hd + dturn : hd - dturn;
            end else begin
                len = (longint'(speed) * longint'(dt) + 128) >> 8;
                trig_of(hd, c, s);
                nx = clip32(px + ((len * c + 64'sh20000000) >>> 30));
                ny = clip32(py + ((len * s + 64'sh20000000) >>> 30));
            end
            reach = mag < longint'(radius);
            if (reach) begin
                cnt = (wp_count < 1) ? 1 : ((wp_count > 16) ? 16 : int'(wp_count));
                tgt = (int'(tgt) + 1 >= cnt) ? 4'd0 : tgt + 4'd1;
                arrivals++;
            end
            if (turn) turns++;
            ticks++;
            u.nx = nx[31:0];
            u.ny = ny[31:0];
            u.nh = nh;
            u.turning = turn;
            u.reached = reach;
            u.slot = tgt;
            pending_updates.push_back(u);
        endfunction

        function void check_result(bit [87:0] d);
            t_pose_update want, got;
            got = d[85:0];
            if (pending_updates.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result transfer %h", got);
                return;
            end
            want = pending_updates.pop_front();
            if (got != want) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch x %h/%h y %h/%h hd %h/%h turn %b/%b",
                              " reach %b/%b slot %0d/%0d"},
                             want.nx, got.nx, want.ny, got.ny, want.nh, got.nh,
                             want.turning, got.turning, want.reached, got.reached,
                             want.slot, got.slot);
            end
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [167:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [87:0]  m_axis_tdata;
    logic         i_cfg_we;
    logic [2:0]   i_cfg_idx;
    logic [30:0]  i_cfg_data;

    follower_scoreboard sb;
    bit no_idle;
    int watch_cnt;
    int ready_left;
    int items_sent;

    waypoint_turn_then_go_follower dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // receiver stalls in bursts unless no_idle is set
    always @(negedge i_clk) begin
        if (ready_left == 0) begin
            m_axis_tready = no_idle ? 1'b1 : 1'($urandom_range(0, 1));
            ready_left = $urandom_range(1, 13);
        end else begin
            ready_left--;
        end
    end

    // result monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
        if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) || !i_rst_n)
            watch_cnt = 0;
        else
            watch_cnt++;
        if (watch_cnt >= WatchLimit) begin
            $display("watchdog: no transfer for %0d cycles", WatchLimit);
            $display("waypoint_turn_then_go_follower_tb: done, errors");
            $finish;
        end
    end

    // one input transfer, with an optional gap in front
    task automatic push(bit kind, bit [167:0] d);
        int gap;
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 13);
            repeat (gap) begin
                @(negedge i_clk);
                s_axis_tvalid = 1'b0;
            end
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser = kind;
        s_axis_tdata = d;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_item(kind, d);
        items_sent++;
    endtask

    task automatic send_load(bit [3:0] slot, bit [31:0] x, bit [31:0] y);
        bit [167:0] d;
        d = 168'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        d[163:96] = {y, x, slot};
        d[167:164] = '0;
        push(KindLoad, d);
    endtask

    task automatic send_tick(bit [31:0] px, bit [31:0] py, bit [15:0] hd, bit [15:0] dt);
        bit [167:0] d;
        d = 168'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        d[95:0] = {dt, hd, py, px};
        d[167:164] = '0;
        push(KindTick, d);
    endtask

    // waits until every pose update has arrived and the block has gone quiet
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (sb.pending_updates.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(bit [2:0] idx, bit [30:0] v);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = v;
        sb.write_reg(idx, v);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // random tick, mostly near the target and often aimed at it
    task automatic random_tick();
        longint px, py;
        bit [15:0] hd, dt;
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) begin
            px = sb.tab_x[sb.tgt] + longint'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
            py = sb.tab_y[sb.tgt] + longint'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
            if (r == 0) begin
                px = sb.tab_x[sb.tgt];
                py = sb.tab_y[sb.tgt];
            end
            px = sb.clip32(px);
            py = sb.clip32(py);
        end else begin
            px = longint'(signed'($urandom));
            py = longint'(signed'($urandom));
        end
        hd = sb.aim_from(px, py);
        if ($urandom_range(0, 2) == 0) hd = 16'($urandom);
        else hd = hd + 16'($signed($urandom_range(0, 4000)) - 2000);
        dt = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000));
        send_tick(px[31:0], py[31:0], hd, dt);
    endtask

    task automatic random_config(int phase);
        case (phase)
            0: begin
                write_reg(CfgCount, 31'd0);
                write_reg(CfgSpeed, 31'd65535);
                write_reg(CfgRate, 31'd65535);
                write_reg(CfgThr, 31'd0);
                write_reg(CfgRad, 31'h7FFFFFFF);
            end
            1: begin
                write_reg(CfgCount, 31'd31);
                write_reg(CfgSpeed, 31'd0);
                write_reg(CfgRate, 31'd0);
                write_reg(CfgThr, 31'd32767);
                write_reg(CfgRad, 31'd0);
            end
            2: begin
                write_reg(CfgCount, 31'd1);
                write_reg(CfgRad, 31'd200000);
            end
            3: begin
                write_reg(CfgCount, 31'd16);
                write_reg(CfgThr, 31'd1043);
                write_reg(CfgSpeed, 31'd154);
                write_reg(CfgRate, 31'd15646);
            end
            default: begin
                write_reg(CfgCount, 31'($urandom_range(0, 31)));
                write_reg(CfgSpeed, 31'($urandom_range(0, 65535)));
                write_reg(CfgRate, 31'($urandom_range(0, 65535)));
                write_reg(CfgThr, 31'($urandom_range(0, 4000)));
                write_reg(CfgRad, 31'($urandom_range(0, 1 << 19)));
                write_reg(CfgUnused, 31'($urandom));
            end
        endcase
    endtask

    initial begin
        sb = new();
        sb.reset_state();
        no_idle = 0;
        ready_left = 0;
        items_sent = 0;
        watch_cnt = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // fill the whole table first, extremes in the low slots
        send_load(4'd0, 32'h00000000, 32'h00000000);
        send_load(4'd1, 32'h7FFFFFFF, 32'h80000000);
        send_load(4'd2, 32'h80000000, 32'h7FFFFFFF);
        for (int i = 3; i < 16; i++) send_load(4'(i), $urandom, $urandom);

        // directed ticks at the reset settings
        send_tick(32'h0, 32'h0, 16'h0000, 16'hFFFF);
        send_tick(32'h7FFFFFFF, 32'h7FFFFFFF, 16'hFFFF, 16'h0000);
        send_tick(32'h80000000, 32'h80000000, 16'h8000, 16'hFFFF);
        send_tick(32'h00010000, 32'h0, 16'h8000, 16'h1000);
        settle();

        // every tick arrives; saturation while driving at full speed
        write_reg(CfgRad, 31'h7FFFFFFF);
        write_reg(CfgThr, 31'd32767);
        write_reg(CfgSpeed, 31'd65535);
        write_reg(CfgCount, 31'd16);
        for (int i = 0; i < 10; i++)
            send_tick(32'h7FFFFFF0, 32'h80000010, 16'(i * 8192), 16'hFFFF);
        settle();

        // index left beyond a shrunken count wraps to zero on arrival
        write_reg(CfgCount, 31'd3);
        send_tick(32'h0, 32'h0, 16'h0, 16'h100);
        send_tick(32'h0, 32'h0, 16'h4000, 16'h100);
        settle();

        // random phases over several settings, the last one without stalls
        for (int p = 0; p < NumPhases; p++) begin
            random_config(p);
            if (p == NumPhases - 1) no_idle = 1;
            for (int n = 0; n < PhaseItems; n++) begin
                if ($urandom_range(0, 19) == 0)
                    send_load(4'($urandom), $urandom, $urandom);
                else
                    random_tick();
            end
            settle();
        end

        $display("covered %0d items: %0d ticks, %0d arrivals, %0d turning ticks",
                 items_sent, sb.ticks, sb.arrivals, sb.turns);
        if (sb.errors == 0 && sb.pending_updates.size() == 0) begin
            $display("waypoint_turn_then_go_follower_tb: done, clean");
        end else begin
            $display("%0d mismatches, %0d updates missing", sb.errors,
                     sb.pending_updates.size());
            $display("waypoint_turn_then_go_follower_tb: done, errors");
        end
        $finish;
    end
endmodule
